// File: rtl/spsm_pkg.sv
// Shared constants and codes for the slotted page slot manager.
// No dependencies; imported by slotted_page_slot_manager_unit.
`default_nettype none

package spsm_pkg;

    // Page geometry
    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 24;
    localparam int SLOT_BYTES   = 4;
    localparam int MAX_SLOTS    = 1024;
    localparam int MAX_LEN      = PAGE_BYTES - HEADER_BYTES - SLOT_BYTES;

    // Field widths
    localparam int FUNC_W  = 3;
    localparam int PID_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int LEN_W   = 13;
    localparam int TOTAL_W = SLOT_W + 1;
    localparam int WORD_W  = 5;              // bits of a slot index inside one bitmap word
    localparam int BMW_W   = SLOT_W - WORD_W; // bitmap word address
    localparam int IN_W    = 64;
    localparam int OUT_W   = 56;

    // Request codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT   = 3'd0,
        FN_GET      = 3'd1,
        FN_UPDATE   = 3'd2,
        FN_DELETE   = 3'd3,
        FN_ROLLBACK = 3'd4,
        FN_REDO     = 3'd5,
        FN_FORMAT   = 3'd6
    } func_t;

endpackage

`default_nettype wire

// File: rtl/slotted_page_slot_manager_unit.sv
// Slot directory manager for one slotted page: slot memory, live bitmap and control.
// Depends on spsm_pkg.
`default_nettype none

// Each request takes one word and returns one word. Get, update, delete,
// rollback delete and redo insert take a slot memory read at accept, a
// read-modify-write step and a step that loads the output register.
// Insert adds one scan step per 32-slot word of the live bitmap that it scans
// for the lowest tombstone, 1 to 32 words. After reset, and for each format,
// a clearing pass writes all 1024 slot entries, one a cycle; no request is
// accepted during the pass. Configuration writes of own_page_id are taken at
// any time. A finished result waits in the output register while the next
// request is accepted.
module slotted_page_slot_manager_unit
    import spsm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [PID_W-1:0] cfg_data,      // own_page_id
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] func, [34:3] req_page_id, [44:35] slot_index, [57:45] record_length
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // [0] ok, [10:1] slot_out, [23:11] record_offset, [36:24] record_size,
    // [49:37] free_bytes
    output logic [OUT_W-1:0]      m_axis_tdata
);

    typedef enum logic [4:0] {
        ST_CLR  = 5'b00001,
        ST_IDLE = 5'b00010,
        ST_SCAN = 5'b00100,
        ST_EXEC = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [LEN_W-1:0]   PAGE_END = LEN_W'(PAGE_BYTES);
    localparam logic [LEN_W-1:0]   LEN_MAX  = LEN_W'(MAX_LEN);
    localparam logic [TOTAL_W-1:0] SLOTS_MAX = TOTAL_W'(MAX_SLOTS);

    // Memories: {offset, size} per slot, and one live bit per slot
    logic [2*LEN_W-1:0]   slot_mem [MAX_SLOTS];
    logic [31:0]          live_mem [MAX_SLOTS/32];
    logic [2*LEN_W-1:0]   slot_q;
    logic [31:0]          live_q;
    logic [SLOT_W-1:0]    slot_rd_addr;
    logic [BMW_W-1:0]     live_rd_addr;
    logic                 mem_we;
    logic [SLOT_W-1:0]    mem_wr_addr;
    logic [2*LEN_W-1:0]   slot_wr_data;
    logic [31:0]          live_wr_data;

    state_t               state_reg, state_next;
    logic [PID_W-1:0]     own_pid_reg;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [LEN_W-1:0]     fp_reg, fp_next;
    logic [SLOT_W-1:0]    clr_cnt_reg;
    logic                 fmt_pend_reg;
    logic [BMW_W-1:0]     scan_w_reg, scan_w_next;
    logic                 found_reg, found_next;
    func_t                func_reg;
    logic [PID_W-1:0]     pid_reg;
    logic [SLOT_W-1:0]    s_reg, s_next;
    logic [LEN_W-1:0]     len_reg;

    logic                 res_ok_reg, res_ok_next;
    logic [SLOT_W-1:0]    res_slot_reg, res_slot_next;
    logic [LEN_W-1:0]     res_off_reg, res_off_next;
    logic [LEN_W-1:0]     res_size_reg, res_size_next;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_data_reg;

    logic                 in_acc;
    func_t                in_func;
    logic [SLOT_W-1:0]    in_slot;

    assign in_func = func_t'(s_axis_tdata[2:0]);
    assign in_slot = s_axis_tdata[44:35];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Free space from the current directory end and free pointer
    logic [LEN_W:0]   dir_end;
    logic [LEN_W-1:0] free_now;
    assign dir_end  = (LEN_W+1)'(HEADER_BYTES) + (LEN_W+1)'({total_reg, 2'b00});
    assign free_now = ({1'b0, fp_reg} < dir_end) ? '0 : LEN_W'({1'b0, fp_reg} - dir_end);

    // Tombstone search inside the current bitmap word
    logic [31:0]        scan_mask, scan_cand;
    logic               scan_hit, scan_more;
    logic [WORD_W-1:0]  scan_bit;
    logic [BMW_W:0]     scan_w_ext;
    always_comb
    begin
        scan_w_ext = {1'b0, scan_w_reg};
        if (scan_w_ext < total_reg[TOTAL_W-1:WORD_W])
            scan_mask = '1;
        else if (scan_w_ext == total_reg[TOTAL_W-1:WORD_W])
            scan_mask = (32'd1 << total_reg[WORD_W-1:0]) - 32'd1;
        else
            scan_mask = '0;
        scan_cand = ~live_q & scan_mask;
        scan_hit  = |scan_cand;
        scan_bit  = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (scan_cand[i])
                scan_bit = WORD_W'(i);
        end
        scan_more = ({scan_w_ext + (BMW_W+1)'(1), {WORD_W{1'b0}}} < total_reg);
    end

    // Read addresses: requests read their slot at accept, insert walks the bitmap
    always_comb
    begin
        slot_rd_addr = s_reg;
        live_rd_addr = s_reg[SLOT_W-1:WORD_W];
        scan_w_next  = scan_w_reg;
        found_next   = found_reg;
        s_next       = s_reg;
        case (state_reg)
            ST_IDLE:
            begin
                slot_rd_addr = in_slot;
                live_rd_addr = (in_func == FN_INSERT) ? '0 : in_slot[SLOT_W-1:WORD_W];
                scan_w_next  = '0;
                found_next   = 1'b0;
                s_next       = in_slot;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    s_next       = {scan_w_reg, scan_bit};
                    found_next   = 1'b1;
                    slot_rd_addr = {scan_w_reg, scan_bit};
                    live_rd_addr = scan_w_reg;
                end
                else if (scan_more)
                begin
                    scan_w_next  = scan_w_reg + BMW_W'(1);
                    live_rd_addr = scan_w_reg + BMW_W'(1);
                end
                else
                begin
                    s_next       = total_reg[SLOT_W-1:0];
                    slot_rd_addr = total_reg[SLOT_W-1:0];
                    live_rd_addr = total_reg[SLOT_W-1:WORD_W];
                end
            end
            default:
            begin
            end
        endcase
    end

    // Execute one request on the slot that was read
    logic [LEN_W-1:0] cur_off, cur_size, placed_off;
    logic             live, page_ok, in_dir, len_ok, fits, fits_app, shrink_ok;
    logic [TOTAL_W-1:0] grow_cnt;
    logic [LEN_W:0]   grow_need;
    logic             do_place, do_shrink, do_kill, ok_c;
    assign cur_off    = slot_q[2*LEN_W-1:LEN_W];
    assign cur_size   = slot_q[LEN_W-1:0];
    assign live       = (cur_size != '0);
    assign page_ok    = (pid_reg == own_pid_reg);
    assign in_dir     = ({1'b0, s_reg} < total_reg);
    assign len_ok     = (len_reg != '0) && (len_reg <= LEN_MAX);
    assign fits       = (free_now >= len_reg);
    assign fits_app   = ({1'b0, free_now} >= ({1'b0, len_reg} + (LEN_W+1)'(SLOT_BYTES)));
    assign shrink_ok  = (len_reg <= cur_size);
    assign placed_off = fp_reg - len_reg;
    assign grow_cnt   = {1'b0, s_reg} + TOTAL_W'(1) - total_reg;
    assign grow_need  = (LEN_W+1)'({grow_cnt, 2'b00}) + {1'b0, len_reg};

    always_comb
    begin
        do_place   = 1'b0;
        do_shrink  = 1'b0;
        do_kill    = 1'b0;
        ok_c       = 1'b0;
        total_next = total_reg;
        case (func_reg)
            FN_INSERT:
            begin
                if (len_ok)
                begin
                    if (found_reg)
                        do_place = fits;
                    else if (total_reg < SLOTS_MAX && fits_app)
                    begin
                        do_place   = 1'b1;
                        total_next = total_reg + TOTAL_W'(1);
                    end
                end
                ok_c = do_place;
            end
            FN_GET:
                ok_c = page_ok && in_dir && live;
            FN_UPDATE:
            begin
                if (page_ok && in_dir && live)
                begin
                    do_shrink = shrink_ok;
                    do_place  = !shrink_ok && fits;
                end
                ok_c = do_shrink || do_place;
            end
            FN_DELETE:
            begin
                do_kill = page_ok && in_dir && live;
                ok_c    = do_kill;
            end
            FN_ROLLBACK:
            begin
                if (page_ok && in_dir)
                begin
                    if (live)
                    begin
                        do_shrink = shrink_ok;
                        do_place  = !shrink_ok && fits;
                    end
                    else
                        do_place = len_ok && fits;
                end
                ok_c = do_shrink || do_place;
            end
            FN_REDO:
            begin
                if (page_ok && len_ok)
                begin
                    if (in_dir)
                    begin
                        if (live)
                        begin
                            do_shrink = shrink_ok;
                            do_place  = !shrink_ok && fits;
                        end
                        else
                            do_place = fits;
                    end
                    else if ({1'b0, free_now} >= grow_need)
                    begin
                        // Grown slots come with the record, so it always fits
                        total_next = {1'b0, s_reg} + TOTAL_W'(1);
                        do_place   = 1'b1;
                    end
                end
                ok_c = do_shrink || do_place;
            end
            FN_FORMAT:
                ok_c = 1'b1;
            default:
            begin
            end
        endcase
    end

    // Result fields and write-back data; an insert that found a tombstone
    // reports that slot even when it is refused for lack of space
    always_comb
    begin
        fp_next       = fp_reg;
        res_ok_next   = ok_c;
        res_slot_next = (func_reg == FN_FORMAT
                         || (func_reg == FN_INSERT && !(found_reg && len_ok))) ? '0 : s_reg;
        res_off_next  = '0;
        res_size_next = '0;
        slot_wr_data  = slot_q;
        live_wr_data  = live_q;
        mem_we        = 1'b0;
        mem_wr_addr   = s_reg;
        if (state_reg == ST_CLR)
        begin
            mem_we       = 1'b1;
            mem_wr_addr  = clr_cnt_reg;
            slot_wr_data = '0;
            live_wr_data = '0;
        end
        else if (state_reg == ST_EXEC)
        begin
            if (func_reg == FN_FORMAT)
            begin
                fp_next      = PAGE_END;
                res_off_next = PAGE_END;
            end
            else if (ok_c)
            begin
                res_slot_next = s_reg;
                res_off_next  = cur_off;
                res_size_next = cur_size;
                if (do_place)
                begin
                    fp_next       = placed_off;
                    res_off_next  = placed_off;
                    res_size_next = len_reg;
                end
                else if (do_shrink)
                    res_size_next = len_reg;
                else if (do_kill)
                    res_size_next = '0;
            end
            mem_we       = do_place || do_shrink || do_kill;
            slot_wr_data = {res_off_next, res_size_next};
            live_wr_data[s_reg[WORD_W-1:0]] = (res_size_next != '0);
        end
    end

    // Memory ports: registered read, one write
    always_ff @(posedge clk)
    begin
        slot_q <= slot_mem[slot_rd_addr];
        live_q <= live_mem[live_rd_addr];
        if (mem_we)
        begin
            slot_mem[mem_wr_addr]                <= slot_wr_data;
            live_mem[mem_wr_addr[SLOT_W-1:WORD_W]] <= live_wr_data;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
                if (clr_cnt_reg == SLOT_W'(MAX_SLOTS - 1))
                    state_next = fmt_pend_reg ? ST_DONE : ST_IDLE;
            ST_IDLE:
                if (in_acc)
                    state_next = (in_func == FN_INSERT) ? ST_SCAN : ST_EXEC;
            ST_SCAN:
                if (scan_hit || !scan_more)
                    state_next = ST_EXEC;
            ST_EXEC:
                state_next = (func_reg == FN_FORMAT) ? ST_CLR : ST_DONE;
            ST_DONE:
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_CLR;
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            own_pid_reg   <= '0;
            total_reg     <= '0;
            fp_reg        <= PAGE_END;
            clr_cnt_reg   <= '0;
            fmt_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                own_pid_reg <= cfg_data;
            // advance the clearing pass
            if (state_reg == ST_CLR)
                clr_cnt_reg <= clr_cnt_reg + SLOT_W'(1);
            if (state_reg == ST_EXEC)
            begin
                fmt_pend_reg <= (func_reg == FN_FORMAT);
                total_reg    <= (func_reg == FN_FORMAT) ? '0 : total_next;
                fp_reg       <= fp_next;
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        scan_w_reg <= scan_w_next;
        found_reg  <= found_next;
        s_reg      <= s_next;
        if (in_acc)
        begin
            func_reg <= in_func;
            pid_reg  <= s_axis_tdata[34:3];
            len_reg  <= s_axis_tdata[57:45];
        end
        if (state_reg == ST_EXEC)
        begin
            res_ok_reg   <= res_ok_next;
            res_slot_reg <= res_slot_next;
            res_off_reg  <= res_off_next;
            res_size_reg <= res_size_next;
        end
        // load the output word with the free space after the operation
        if (state_reg == ST_DONE && state_next == ST_IDLE)
            out_data_reg <= {6'd0, free_now, res_size_reg, res_off_reg,
                             res_slot_reg, res_ok_reg};
    end

endmodule

`default_nettype wire
